// ===== rtl/flash_command_sequencer_core_defines.svh =====
// Assertion macros shared by the flash command sequencer RTL.
`ifndef FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define FCS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcs check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define FCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcs check failed");

`endif

// ===== rtl/fcs_pkg.sv =====
// Types, codes and constants shared by the flash command sequencer modules.
package fcs_pkg;

  // Default geometry; the sector size is a power of two
  localparam int STORE_BYTES_DEF  = 524288;
  localparam int SECTOR_BYTES_DEF = 4096;

  // Field widths
  localparam int ADDR_W     = 19;
  localparam int DATA_W     = 8;
  localparam int ROM_SIZE_W = 20;

  localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET = 20'h80000;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Command cycle addresses (low 16 address bits)
  localparam logic [15:0] ADDR_CMD1 = 16'h5555;
  localparam logic [15:0] ADDR_CMD2 = 16'h2AAA;

  // Command bytes
  localparam logic [DATA_W-1:0] BYTE_UNLOCK1    = 8'hAA;
  localparam logic [DATA_W-1:0] BYTE_UNLOCK2    = 8'h55;
  localparam logic [DATA_W-1:0] BYTE_ERASE_SET  = 8'h80;
  localparam logic [DATA_W-1:0] BYTE_ID_ENTRY   = 8'h90;
  localparam logic [DATA_W-1:0] BYTE_PROGRAM    = 8'hA0;
  localparam logic [DATA_W-1:0] BYTE_RESET      = 8'hF0;
  localparam logic [DATA_W-1:0] BYTE_CHIP_ERASE = 8'h10;
  localparam logic [DATA_W-1:0] BYTE_SECT_ERASE = 8'h30;

  // Read values
  localparam logic [DATA_W-1:0] ID_EVEN     = 8'hBF;
  localparam logic [DATA_W-1:0] ID_ODD      = 8'hB5;
  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;
  localparam logic [DATA_W-1:0] WRITE_REPLY = 8'h00;

  // Command mode
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ERASE   = 2'd1,
    MODE_PROGRAM = 2'd2
  } mode_t;

  // Command cycle counter values
  localparam logic [2:0] STEP_START   = 3'd0;
  localparam logic [2:0] STEP_UNLOCK1 = 3'd1;
  localparam logic [2:0] STEP_UNLOCK2 = 3'd2;
  localparam logic [2:0] STEP_ERASE0  = 3'd3;
  localparam logic [2:0] STEP_ERASE1  = 3'd4;
  localparam logic [2:0] STEP_ERASE2  = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic take;        // capture the input transfer, start the store read
    logic exec;        // decode the access and update the command state
    logic sweep;       // write one erased byte and advance the sweep
    logic out_direct;  // load the output register from the decode
    logic out_held;    // load the output register from the held result
  } fcs_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_req;   // the access asks for an erase sweep
    logic sweep_last;  // the sweep writes its last byte this cycle
    logic out_free;    // the output register can take a result
  } fcs_status_t;

endpackage

// ===== rtl/flash_command_sequencer_core.sv =====
// Top level of the flash command sequencer: controller, datapath and checks.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    command, address, write_data
//  out      output     out_valid / out_stall  read_data, flash_dirty, id_mode
//  cfg      input      cfg_valid / cfg_ready  rom_size
//
// After reset a clearing pass writes every store byte to 0xFF, with in_stall
// high; configuration writes are taken throughout.
// An access is a transfer, then a decode on the registered store read; the
// block takes no new access until it has decoded the last one.
// Chip erase sweeps every byte in use, a sector erase that fits its
// SECTOR_BYTES bytes; the store sweep writes one byte a cycle. An erase
// with nothing to clear starts no sweep.
// A stalled output holds its result; the block then keeps in_stall high
// once it has a second result ready.
module flash_command_sequencer_core #(
  parameter int STORE_BYTES  = fcs_pkg::STORE_BYTES_DEF,
  parameter int SECTOR_BYTES = fcs_pkg::SECTOR_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [fcs_pkg::ADDR_W-1:0]     address,
  input  logic [fcs_pkg::DATA_W-1:0]     write_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fcs_pkg::DATA_W-1:0]     read_data,
  output logic                           flash_dirty,
  output logic                           id_mode,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcs_pkg::ROM_SIZE_W-1:0] rom_size
);
  import fcs_pkg::*;

`include "flash_command_sequencer_core_defines.svh"

  fcs_ctrl_t   ctl;
  fcs_status_t st;

  // The register takes a write in any cycle
  assign cfg_ready = 1'b1;

  fcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  fcs_datapath #(
    .STORE_BYTES  (STORE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .cfg_we      (cfg_valid && cfg_ready),
    .rom_size    (rom_size),
    .command     (command),
    .address     (address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .flash_dirty (flash_dirty),
    .id_mode     (id_mode)
  );

  // One item at a time: busy right after a transfer in
  `FCS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // A result appears only out of work on an accepted item
  `FCS_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(in_stall))
  // No transfer in while the store is being swept
  `FCS_ASSERT_IMPL(a_no_take_in_sweep, ctl.sweep, in_stall)

endmodule

// ===== rtl/fcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcs_ctrl.sv =====
// Controller state machine of the flash command sequencer.
module fcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcs_pkg::fcs_status_t st,
  output fcs_pkg::fcs_ctrl_t   ctl
);
  import fcs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DELIVER
  } state_t;

  state_t state;

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (st.sweep_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (st.sweep_req) state <= S_SWEEP;
          else if (st.out_free) state <= S_IDLE;
          else state <= S_DELIVER;
        end
        S_SWEEP: begin
          if (st.sweep_last) state <= S_DELIVER;
        end
        S_DELIVER: begin
          if (st.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Accept only while idle
  assign in_stall = (state != S_IDLE);

  // Drive datapath commands
  always_comb begin
    ctl.take       = (state == S_IDLE) && in_valid;
    ctl.exec       = (state == S_EXEC);
    ctl.sweep      = (state == S_CLEAR) || (state == S_SWEEP);
    ctl.out_direct = (state == S_EXEC) && !st.sweep_req && st.out_free;
    ctl.out_held   = (state == S_DELIVER) && st.out_free;
  end

endmodule

// ===== rtl/fcs_datapath.sv =====
// Datapath: byte store, command decode, erase sweep and output register.
module fcs_datapath #(
  parameter int STORE_BYTES  = fcs_pkg::STORE_BYTES_DEF,
  parameter int SECTOR_BYTES = fcs_pkg::SECTOR_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fcs_pkg::fcs_ctrl_t                ctl,
  output fcs_pkg::fcs_status_t              st,
  input  logic                              cfg_we,
  input  logic [fcs_pkg::ROM_SIZE_W-1:0]    rom_size,
  input  logic                              command,
  input  logic [fcs_pkg::ADDR_W-1:0]        address,
  input  logic [fcs_pkg::DATA_W-1:0]        write_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fcs_pkg::DATA_W-1:0]        read_data,
  output logic                              flash_dirty,
  output logic                              id_mode
);
  import fcs_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);
  localparam logic [31:0]       STORE_LIM   = 32'(STORE_BYTES);
  localparam logic [31:0]       SECT_LEN    = 32'(SECTOR_BYTES);
  localparam logic [ADDR_W-1:0] SECT_MASK   = ADDR_W'(SECTOR_BYTES - 1);
  localparam logic [CW-1:0]     SECT_COUNT  = CW'(SECTOR_BYTES);
  localparam logic [CW-1:0]     STORE_COUNT = CW'(STORE_BYTES);

  // Configuration and command state
  logic [ROM_SIZE_W-1:0] cfg_size;
  mode_t                 op_mode;
  logic [2:0]            step;
  logic                  sid;
  logic                  dirty;

  // Captured item
  logic              item_cmd;
  logic [ADDR_W-1:0] item_addr;
  logic [DATA_W-1:0] item_data;

  // Erase sweep
  logic [AW-1:0] sweep_addr;
  logic [CW-1:0] sweep_left;

  // Held result
  logic [DATA_W-1:0] res_data;
  logic              res_dirty;
  logic              res_id;

  // Store ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] rdata;

  // Decode results
  logic [31:0]           size32;
  logic [ROM_SIZE_W-1:0] size;
  logic                  in_range;
  logic [15:0]           low;
  logic [AW-1:0]         item_idx;
  logic [ADDR_W-1:0]     base;
  logic                  fit;
  logic [DATA_W-1:0]     nv;
  mode_t                 mode_next;
  logic [2:0]            step_next;
  logic                  sid_next;
  logic                  dirty_next;
  logic                  prog_we;
  logic                  chip_go;
  logic                  sect_go;
  logic [DATA_W-1:0]     rd_val;

  fcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Size in use and address checks
  always_comb begin
    size32   = (32'(cfg_size) < STORE_LIM) ? 32'(cfg_size) : STORE_LIM;
    size     = size32[ROM_SIZE_W-1:0];
    in_range = (ROM_SIZE_W'(item_addr) < size);
    low      = item_addr[15:0];
    item_idx = AW'(32'(item_addr));
    base     = item_addr & ~SECT_MASK;
    fit      = ((32'(base) + SECT_LEN) <= size32);
    nv       = rdata & item_data;
  end

  // Read at the input address when the transfer is taken
  assign ram_raddr = AW'(32'(address));

  // Decode one access
  always_comb begin
    mode_next  = op_mode;
    step_next  = step;
    sid_next   = sid;
    dirty_next = dirty;
    prog_we    = 1'b0;
    chip_go    = 1'b0;
    sect_go    = 1'b0;
    rd_val     = WRITE_REPLY;
    if (item_cmd == CMD_READ) begin
      if (sid) rd_val = item_addr[0] ? ID_ODD : ID_EVEN;
      else if (in_range) rd_val = rdata;
      else rd_val = ERASED_BYTE;
    end else begin
      unique case (op_mode)
        MODE_PROGRAM: begin
          if (in_range && (nv != rdata)) begin
            prog_we    = 1'b1;
            dirty_next = 1'b1;
          end
          mode_next = MODE_IDLE;
          step_next = STEP_START;
        end
        MODE_ERASE: begin
          if (step == STEP_ERASE0 && low == ADDR_CMD1 && item_data == BYTE_UNLOCK1) begin
            step_next = STEP_ERASE1;
          end else if (step == STEP_ERASE1 && low == ADDR_CMD2 &&
                       item_data == BYTE_UNLOCK2) begin
            step_next = STEP_ERASE2;
          end else begin
            if (step == STEP_ERASE2) begin
              if (low == ADDR_CMD1 && item_data == BYTE_CHIP_ERASE) begin
                chip_go    = (size != '0);
                dirty_next = 1'b1;
              end else if (item_data == BYTE_SECT_ERASE && fit) begin
                sect_go    = 1'b1;
                dirty_next = 1'b1;
              end
            end
            mode_next = MODE_IDLE;
            step_next = STEP_START;
          end
        end
        MODE_IDLE: begin
          unique case (step)
            STEP_START: begin
              if (low == ADDR_CMD1 && item_data == BYTE_UNLOCK1) step_next = STEP_UNLOCK1;
              else if (item_data == BYTE_RESET) sid_next = 1'b0;
            end
            STEP_UNLOCK1: begin
              step_next = (low == ADDR_CMD2 && item_data == BYTE_UNLOCK2) ?
                          STEP_UNLOCK2 : STEP_START;
            end
            STEP_UNLOCK2: begin
              step_next = STEP_START;
              if (low == ADDR_CMD1) begin
                unique case (item_data)
                  BYTE_ERASE_SET: begin
                    mode_next = MODE_ERASE;
                    step_next = STEP_ERASE0;
                  end
                  BYTE_ID_ENTRY: sid_next  = 1'b1;
                  BYTE_PROGRAM:  mode_next = MODE_PROGRAM;
                  BYTE_RESET:    sid_next  = 1'b0;
                  default: ;
                endcase
              end
            end
            default: begin
              mode_next = MODE_IDLE;
              step_next = STEP_START;
            end
          endcase
        end
        default: begin
          mode_next = MODE_IDLE;
          step_next = STEP_START;
        end
      endcase
    end
  end

  // Store write: sweep bytes or the programmed byte
  always_comb begin
    ram_we    = ctl.sweep || (ctl.exec && prog_we);
    ram_waddr = ctl.sweep ? sweep_addr : item_idx;
    ram_wdata = ctl.sweep ? ERASED_BYTE : nv;
  end

  // Status to the controller
  always_comb begin
    st.sweep_req  = chip_go || sect_go;
    st.sweep_last = (sweep_left == CW'(1));
    st.out_free   = !out_valid || !out_stall;
  end

  // Hold configuration and command state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size <= ROM_SIZE_RESET;
      op_mode  <= MODE_IDLE;
      step     <= STEP_START;
      sid      <= 1'b0;
      dirty    <= 1'b0;
    end else begin
      if (cfg_we) cfg_size <= rom_size;
      if (ctl.exec) begin
        op_mode <= mode_next;
        step    <= step_next;
        sid     <= sid_next;
        dirty   <= dirty_next;
      end
    end
  end

  // Capture the item and hold the result
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      item_cmd  <= command;
      item_addr <= address;
      item_data <= write_data;
    end
    if (ctl.exec) begin
      res_data  <= rd_val;
      res_dirty <= dirty_next;
      res_id    <= sid_next;
    end
  end

  // Advance the erase sweep; reset starts a full clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_left <= STORE_COUNT;
    end else if (ctl.exec && chip_go) begin
      sweep_addr <= '0;
      sweep_left <= size32[CW-1:0];
    end else if (ctl.exec && sect_go) begin
      sweep_addr <= AW'(32'(base));
      sweep_left <= SECT_COUNT;
    end else if (ctl.sweep) begin
      sweep_addr <= sweep_addr + AW'(1);
      sweep_left <= sweep_left - CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_direct || ctl.out_held) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_direct) begin
      read_data   <= rd_val;
      flash_dirty <= dirty_next;
      id_mode     <= sid_next;
    end else if (ctl.out_held) begin
      read_data   <= res_data;
      flash_dirty <= res_dirty;
      id_mode     <= res_id;
    end
  end

endmodule
